>>> rtl/core/sleep_queue_tick_waker_top_assert.svh
// Assertion macros for the sleep queue tick waker. Each check is sampled on
// the rising edge of clk and is switched off while rst is high.
`ifndef SLEEP_QUEUE_TICK_WAKER_TOP_ASSERT_SVH
`define SLEEP_QUEUE_TICK_WAKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SQTW_ASSERT_SAME(name, cond_a, cond_c) \
  name: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_c)) \
    else $error("sqtw same-cycle check failed");

`define SQTW_ASSERT_NEXT(name, cond_a, cond_c) \
  name: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_c)) \
    else $error("sqtw next-cycle check failed");

`else

`define SQTW_ASSERT_SAME(name, cond_a, cond_c)

`define SQTW_ASSERT_NEXT(name, cond_a, cond_c)

`endif

`endif

>>> rtl/core/sqtw_pkg.sv
`timescale 1ns / 1ps

package sqtw_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PID_W  = 8;
  localparam int TICK_W = 48;
  localparam int SUM_W  = 56;
  localparam int CORE_W = 7;

  localparam logic [CORE_W-1:0] CORE_COUNT_RESET = CORE_W'(4);

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_WOKEN = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef struct packed {
    logic              mode;
    logic [PID_W-1:0]  proc_id;
    logic [TICK_W-1:0] wake_tick;
    logic [CORE_W-1:0] active_cores;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [PID_W-1:0]  woken_id;
    logic              last;
    logic [TICK_W-1:0] tick_now;
    logic [SUM_W-1:0]  active_total;
    logic [SUM_W-1:0]  idle_total;
    logic [SUM_W-1:0]  core_tick_total;
  } out_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [TICK_W-1:0]  deadline;
  } entry_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_now;
    logic [SUM_W-1:0]  active_total;
    logic [SUM_W-1:0]  idle_total;
    logic [SUM_W-1:0]  core_tick_total;
  } stats_t;

endpackage

>>> rtl/core/sleep_queue_tick_waker_top.sv
`timescale 1ns / 1ps

// Sleep queue with tick-driven wakeup and saturating core utilization totals.
// Input channel (in_valid/in_ready/in_data): an add item appends a process id
// with its wake tick, a tick item advances the tick counter, updates the three
// utilization totals and releases every entry whose wake tick has come.
// Output channel (out_valid/out_ready/out_data): an add gives one item (added
// or full); a tick gives one item per released process in table order, or a
// single "none woken" item. The final item of each input carries last.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) sets the core count; it
// is always ready and is meant to be written while the block is idle.
// Scan: a tick reads each stored entry through the read port of the entry
// memory and writes each kept entry back through its write port, one entry
// per cycle while no stalled receiver holds the scan.
// One item is in work at a time; in_ready is high while the sequencer idles.
// A stalled receiver holds the scan once a second result is ready, while the
// output register keeps the waiting item. A new input item is accepted while
// that register still holds a result.
// Reset (synchronous, rst high) empties the table, clears the counters and
// loads the core count with 4; no clearing pass is needed.

module sleep_queue_tick_waker_top import sqtw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CORE_W-1:0] cfg_data
);

`include "sleep_queue_tick_waker_top_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD_OUT,
    S_SCAN,
    S_FIN
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   kept;
  logic               hold_valid;
  logic [ID_BITS-1:0] hold_id;
  status_t            add_status;
  logic [CORE_W-1:0]  core_count;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic               has_room;
  logic               woken;
  logic               stall;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_entry;
  entry_t             rd_entry;
  stats_t             stats;

  function automatic out_item_t make_out(status_t st, logic [ID_BITS-1:0] id,
                                         logic lst, stats_t s);
    out_item_t o;
    o.status          = st;
    o.woken_id        = PID_W'(id);
    o.last            = lst;
    o.tick_now        = s.tick_now;
    o.active_total    = s.active_total;
    o.idle_total      = s.idle_total;
    o.core_tick_total = s.core_tick_total;
    return o;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign has_room  = (cnt < CNT_W'(TABLE_DEPTH));

  assign woken = (rd_entry.deadline <= stats.tick_now);
  // The first released entry only moves into the hold register, so the scan
  // waits on the output only when a second one has to push the first out.
  assign stall = woken && hold_valid && !out_free;

  // A new result enters the output register only when it is free.
  assign out_load = ((state == S_ADD_OUT) && out_free) ||
                    ((state == S_SCAN) && !stall && woken && hold_valid) ||
                    ((state == S_FIN) && out_free);

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = cnt[IDX_W-1:0];
    wr_entry = '{id: ID_BITS'(in_data.proc_id), deadline: in_data.wake_tick};
    if (state == S_SCAN) begin
      rd_en    = !stall && (rd_idx < cnt);
      rd_addr  = rd_idx[IDX_W-1:0];
      wr_en    = !stall && !woken;
      wr_addr  = kept[IDX_W-1:0];
      wr_entry = rd_entry;
    end else if (in_acc) begin
      rd_en = in_data.mode && (cnt != '0);
      wr_en = !in_data.mode && has_room;
    end
  end

  sqtw_mem u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  sqtw_acct u_acct (
    .clk          (clk),
    .rst          (rst),
    .tick         (in_acc && in_data.mode),
    .active_cores (in_data.active_cores),
    .core_count   (core_count),
    .stats        (stats)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      rd_idx     <= '0;
      kept       <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      core_count <= CORE_COUNT_RESET;
    end else begin
      if (cfg_valid) begin
        core_count <= cfg_data;
      end
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.mode) begin
              rd_idx     <= CNT_W'(1);
              kept       <= '0;
              hold_valid <= 1'b0;
              state      <= (cnt != '0) ? S_SCAN : S_FIN;
            end else begin
              if (has_room) begin
                cnt        <= cnt + CNT_W'(1);
                add_status <= ST_ADDED;
              end else begin
                add_status <= ST_FULL;
              end
              state <= S_ADD_OUT;
            end
          end
        end
        S_ADD_OUT: begin
          if (out_free) begin
            out_data <= make_out(add_status, '0, 1'b1, stats);
            state    <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (!stall) begin
            if (woken) begin
              if (hold_valid) begin
                out_data <= make_out(ST_WOKEN, hold_id, 1'b0, stats);
              end
              hold_id    <= rd_entry.id;
              hold_valid <= 1'b1;
            end else begin
              kept <= kept + CNT_W'(1);
            end
            if (rd_idx < cnt) begin
              rd_idx <= rd_idx + CNT_W'(1);
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (hold_valid) begin
              out_data <= make_out(ST_WOKEN, hold_id, 1'b1, stats);
            end else begin
              out_data <= make_out(ST_NONE, '0, 1'b1, stats);
            end
            hold_valid <= 1'b0;
            cnt        <= kept;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SQTW_ASSERT_SAME(a_cnt_bound, 1'b1, cnt <= CNT_W'(TABLE_DEPTH))
  `SQTW_ASSERT_SAME(a_write_behind_read, state == S_SCAN, kept < rd_idx)
  `SQTW_ASSERT_SAME(a_idle_no_hold, state == S_IDLE, !hold_valid)
  `SQTW_ASSERT_NEXT(a_fin_done, (state == S_FIN) && out_free,
                    (state == S_IDLE) && out_valid && out_data.last)

endmodule

>>> rtl/core/sqtw_mem.sv
`timescale 1ns / 1ps

module sqtw_mem import sqtw_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_entry,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_entry
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Read data holds while rd_en is low so a stalled scan keeps its entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/sqtw_acct.sv
`timescale 1ns / 1ps

module sqtw_acct import sqtw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic [CORE_W-1:0] active_cores,
  input  logic [CORE_W-1:0] core_count,
  output stats_t            stats
);

  logic [TICK_W-1:0] tick_counter;
  logic [SUM_W-1:0]  active_sum;
  logic [SUM_W-1:0]  idle_sum;
  logic [SUM_W-1:0]  total_sum;
  logic [CORE_W-1:0] act_clamped;
  logic [CORE_W-1:0] idle_inc;
  logic [SUM_W:0]    active_raw;
  logic [SUM_W:0]    idle_raw;
  logic [SUM_W:0]    total_raw;

  assign act_clamped = (active_cores > core_count) ? core_count : active_cores;
  assign idle_inc    = core_count - act_clamped;

  // A sum below the maximum plus a 7-bit increment can only carry into the top bit.
  assign active_raw = {1'b0, active_sum} + (SUM_W + 1)'(act_clamped);
  assign idle_raw   = {1'b0, idle_sum} + (SUM_W + 1)'(idle_inc);
  assign total_raw  = {1'b0, total_sum} + (SUM_W + 1)'(core_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      active_sum   <= '0;
      idle_sum     <= '0;
      total_sum    <= '0;
    end else if (tick) begin
      tick_counter <= tick_counter + TICK_W'(1);
      active_sum   <= active_raw[SUM_W] ? '1 : active_raw[SUM_W-1:0];
      idle_sum     <= idle_raw[SUM_W] ? '1 : idle_raw[SUM_W-1:0];
      total_sum    <= total_raw[SUM_W] ? '1 : total_raw[SUM_W-1:0];
    end
  end

  assign stats.tick_now        = tick_counter;
  assign stats.active_total    = active_sum;
  assign stats.idle_total      = idle_sum;
  assign stats.core_tick_total = total_sum;

endmodule
